/* design/assert_macros.svh */
// assertion macros shared by the allocator rtl
// expects a clock named clk and an active-low reset named rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/sha_pkg.sv */
// types and constants for the slot handle allocator
// no dependencies
`timescale 1ns / 1ps

package sha_pkg;

    localparam int POOL_SLOTS = 1024;
    localparam int HANDLE_W   = $clog2(POOL_SLOTS);
    localparam int COUNT_W    = HANDLE_W + 1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_COMPACT = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_NOT_ISSUED = 2'd2,
        ST_NONE_LIVE  = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [HANDLE_W-1:0]   handle;
    } cmd_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]   given_handle;
        status_t               status;
        logic [COUNT_W-1:0]    live_count;
    } result_t;

endpackage

/* design/slot_handle_allocator.sv */
// slot handle allocator: lifo free stack plus high-water mark
// depends on sha_pkg and assert_macros.svh
`timescale 1ns / 1ps
//
// usage
//   command channel: cmd (opcode, handle) is taken at a rising edge with start
//   high and busy low. busy is held low, so a command beat can be given every
//   cycle.
//   result channel: done pulses for one cycle, in the cycle after the command
//   edge, with given_handle, status and live_count on result. every command
//   yields exactly one result beat.
//   throughput is one command per cycle. counter updates
//   happen at the command edge; a pop reads the stack memory at that same
//   edge through its registered read port, so the next command already sees
//   the new stack top and depth.
//   reset clears the stack depth, the high-water mark and the result strobe.
//   stack memory contents are not cleared; only entries below the depth are
//   read, and all of those were written by earlier frees.
//   the receiver cannot stall: each result beat is present for one cycle only
//   and must be taken then.
//
module slot_handle_allocator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sha_pkg::cmd_t   cmd,
    output logic            done,
    output sha_pkg::result_t result
);
    import sha_pkg::*;

    `include "assert_macros.svh"

    localparam logic [COUNT_W-1:0] POOL_CNT = COUNT_W'(POOL_SLOTS);
    localparam logic [COUNT_W-1:0] ONE_CNT  = COUNT_W'(1);

    logic [HANDLE_W-1:0] stack_mem [POOL_SLOTS];

    logic [COUNT_W-1:0]  free_depth_reg, free_depth_next;
    logic [COUNT_W-1:0]  high_water_reg, high_water_next;

    logic                done_reg;
    logic                from_stack_reg;
    logic [HANDLE_W-1:0] rd_data_reg;
    logic [HANDLE_W-1:0] hw_given_reg;
    status_t             status_reg;
    logic [COUNT_W-1:0]  live_reg;

    logic                accept;
    logic                pop;
    logic                push;
    logic [HANDLE_W-1:0] hw_given;
    status_t             status_next;
    logic [COUNT_W-1:0]  live_now;
    logic [COUNT_W-1:0]  live_next;
    logic [COUNT_W-1:0]  depth_inc;
    logic [HANDLE_W-1:0] pop_addr;
    logic [HANDLE_W-1:0] push_addr;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign live_now  = high_water_reg - free_depth_reg;
    assign depth_inc = free_depth_reg + ONE_CNT;
    assign pop_addr  = HANDLE_W'(free_depth_reg - ONE_CNT);
    assign push_addr = free_depth_reg[HANDLE_W-1:0];

    always_comb
    begin
        free_depth_next = free_depth_reg;
        high_water_next = high_water_reg;
        pop             = 1'b0;
        push            = 1'b0;
        hw_given        = '0;
        status_next     = ST_OK;
        case (cmd.opcode)
            OP_ALLOC:
            begin
                if (free_depth_reg != '0)
                begin
                    pop             = 1'b1;
                    free_depth_next = free_depth_reg - ONE_CNT;
                end
                else if (high_water_reg < POOL_CNT)
                begin
                    hw_given        = high_water_reg[HANDLE_W-1:0];
                    high_water_next = high_water_reg + ONE_CNT;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
            OP_FREE:
            begin
                if (live_now == '0)
                begin
                    status_next = ST_NONE_LIVE;
                end
                else if ({1'b0, cmd.handle} >= high_water_reg)
                begin
                    status_next = ST_NOT_ISSUED;
                end
                else
                begin
                    push = 1'b1;
                    if (depth_inc == high_water_reg)
                    begin
                        free_depth_next = '0;
                        high_water_next = '0;
                    end
                    else
                    begin
                        free_depth_next = depth_inc;
                    end
                end
            end
            OP_COMPACT:
            begin
                high_water_next = live_now;
                free_depth_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign live_next = high_water_next - free_depth_next;

    // stack memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (accept && push)
        begin
            stack_mem[push_addr] <= cmd.handle;
        end
        if (accept && pop)
        begin
            rd_data_reg <= stack_mem[pop_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_depth_reg <= '0;
            high_water_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                free_depth_reg <= free_depth_next;
                high_water_reg <= high_water_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            from_stack_reg <= pop;
            hw_given_reg   <= hw_given;
            status_reg     <= status_next;
            live_reg       <= live_next;
        end
    end

    assign done                = done_reg;
    assign result.given_handle = from_stack_reg ? rd_data_reg : hw_given_reg;
    assign result.status       = status_reg;
    assign result.live_count   = live_reg;

    `ASSERT_CLK(a_depth_le_mark, free_depth_reg <= high_water_reg,
        "free stack deeper than high-water mark")
    `ASSERT_CLK(a_mark_le_pool, high_water_reg <= POOL_CNT,
        "high-water mark beyond pool size")
    `ASSERT_NEXT(a_done_follows, accept, done_reg,
        "command beat without result beat")
    `ASSERT_CLK(a_live_matches, !done_reg || (live_reg == live_now),
        "reported live count differs from counters")

endmodule

/* test/slot_handle_allocator_test.sv */
// self-checking testbench for slot_handle_allocator: queue-fed command driver,
// strobe monitor and a cycle-level pool predictor checked field by field
// depends on sha_pkg and the slot_handle_allocator rtl
`timescale 1ns / 1ps

module slot_handle_allocator_test;

    import sha_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         GAP_PCT     = 13;
    localparam int         STALL_LIMIT = 2000;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    cmd_t    cmd;
    logic    done;
    result_t result;

    cmd_t    cmd_backlog[$];
    result_t owed_results[$];

    // pool predictor state
    logic [HANDLE_W-1:0] stack_mem [POOL_SLOTS];
    logic [COUNT_W-1:0]  stack_depth;
    logic [COUNT_W-1:0]  issued_top;

    logic took_last;
    int   n_taken;
    int   n_results;
    int   n_errors;
    int   stall_cycles;
    int   n_full;
    int   n_not_issued;
    int   n_none_live;
    int   n_collapse;
    int   n_compact;
    int   n_unknown;
    int   n_granted;
    int   fill_guard;

    slot_handle_allocator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        n_errors++;
    endtask

    // applies one accepted command to the pool and records the result it owes
    task automatic pool_step(input cmd_t c);
        result_t r;
        r = '0;
        r.status = ST_OK;
        case (c.opcode)
            OP_ALLOC:
            begin
                if (stack_depth != '0)
                begin
                    stack_depth--;
                    r.given_handle = stack_mem[stack_depth[HANDLE_W-1:0]];
                    n_granted++;
                end
                else if (issued_top < POOL_SLOTS)
                begin
                    r.given_handle = issued_top[HANDLE_W-1:0];
                    issued_top++;
                    n_granted++;
                end
                else
                begin
                    r.status = ST_FULL;
                    n_full++;
                end
            end
            OP_FREE:
            begin
                if (issued_top == stack_depth)
                begin
                    r.status = ST_NONE_LIVE;
                    n_none_live++;
                end
                else if (c.handle >= issued_top)
                begin
                    r.status = ST_NOT_ISSUED;
                    n_not_issued++;
                end
                else
                begin
                    stack_mem[stack_depth[HANDLE_W-1:0]] = c.handle;
                    stack_depth++;
                    if (stack_depth == issued_top)
                    begin
                        stack_depth = '0;
                        issued_top  = '0;
                        n_collapse++;
                    end
                end
            end
            OP_COMPACT:
            begin
                issued_top  = issued_top - stack_depth;
                stack_depth = '0;
                n_compact++;
            end
            default:
            begin
                n_unknown++;
            end
        endcase
        r.live_count = issued_top - stack_depth;
        owed_results = {owed_results, r};
    endtask

    // keeps the backlog short so random frees see a nearly current pool
    task automatic send(input opcode_t op, input logic [HANDLE_W-1:0] h);
        cmd_t c;
        c.opcode = op;
        c.handle = h;
        while (cmd_backlog.size() >= 3)
            @(negedge clk);
        cmd_backlog = {cmd_backlog, c};
    endtask

    task automatic churn(input int pct_alloc, input int pct_free, input int pct_compact);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < pct_alloc)
            send(OP_ALLOC, HANDLE_W'($urandom_range(0, POOL_SLOTS - 1)));
        else if (roll < pct_alloc + pct_free)
        begin
            if (issued_top != '0)
                send(OP_FREE, HANDLE_W'($urandom_range(0, int'(issued_top) - 1)));
            else
                send(OP_FREE, HANDLE_W'($urandom_range(0, POOL_SLOTS - 1)));
        end
        else if (roll < pct_alloc + pct_free + pct_compact)
            send(OP_COMPACT, HANDLE_W'($urandom_range(0, POOL_SLOTS - 1)));
        else
        begin
            case ($urandom_range(0, 2))
                0:       send(OP_FREE, HANDLE_W'($urandom_range(0, POOL_SLOTS - 1)));
                1:       send(opcode_t'(OP_UNUSED),
                              HANDLE_W'($urandom_range(0, POOL_SLOTS - 1)));
                default: send(OP_FREE, issued_top[HANDLE_W-1:0]);
            endcase
        end
    endtask

    // holds the sender off until every command is taken and answered
    task automatic wait_quiet();
        @(posedge clk);
        while (cmd_backlog.size() != 0 || start)
            @(posedge clk);
        @(negedge clk);
        while (n_results < n_taken)
            @(negedge clk);
    endtask

    // command driver
    initial
    begin
        start = 1'b0;
        cmd   = '0;
    end

    always @(negedge clk)
    begin
        if (rst_n && !(start && !took_last))
        begin
            if (cmd_backlog.size() != 0 &&
                ((n_taken >= 600 && n_taken < 900) || $urandom_range(0, 99) >= GAP_PCT))
            begin
                start <= 1'b1;
                cmd   <= cmd_backlog.pop_front();
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // result monitor and predictor update
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                n_results++;
                if (owed_results.size() == 0)
                    report_mismatch("result beat with nothing outstanding");
                else
                begin
                    result_t want;
                    want = owed_results.pop_front();
                    if (result.given_handle !== want.given_handle)
                        report_mismatch($sformatf("given_handle %0d, wanted %0d",
                                                  result.given_handle, want.given_handle));
                    if (result.status !== want.status)
                        report_mismatch($sformatf("status %0d, wanted %0d",
                                                  result.status, want.status));
                    if (result.live_count !== want.live_count)
                        report_mismatch($sformatf("live_count %0d, wanted %0d",
                                                  result.live_count, want.live_count));
                end
            end
            if (start && !busy)
            begin
                n_taken++;
                pool_step(cmd);
            end
        end
        took_last <= rst_n && start && !busy;
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || done))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        stack_depth  = '0;
        issued_top   = '0;
        took_last    = 1'b0;
        n_taken      = 0;
        n_results    = 0;
        n_errors     = 0;
        stall_cycles = 0;
        n_full       = 0;
        n_not_issued = 0;
        n_none_live  = 0;
        n_collapse   = 0;
        n_compact    = 0;
        n_unknown    = 0;
        n_granted    = 0;
        fill_guard   = 0;
        rst_n        = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty pool corner cases
        send(OP_FREE, '0);
        send(OP_FREE, '1);
        send(OP_COMPACT, '1);
        send(opcode_t'(OP_UNUSED), '0);
        // fresh grants, never-issued frees at and past the mark
        send(OP_ALLOC, '1);
        send(OP_ALLOC, '0);
        send(OP_ALLOC, '0);
        send(OP_FREE, '1);
        send(OP_FREE, 10'd3);
        // lifo reuse
        send(OP_FREE, 10'd1);
        send(OP_ALLOC, '0);
        send(OP_FREE, 10'd2);
        send(OP_FREE, 10'd0);
        send(OP_ALLOC, '0);
        // compact with stacked frees, then free everything to collapse
        send(OP_FREE, 10'd1);
        send(OP_COMPACT, '0);
        send(OP_ALLOC, '0);
        send(OP_FREE, 10'd0);
        send(OP_FREE, 10'd1);
        send(OP_FREE, 10'd1);
        send(OP_ALLOC, '1);
        send(opcode_t'(OP_UNUSED), '1);
        send(OP_FREE, 10'd0);

        wait_quiet();

        repeat (200) churn(45, 35, 5);

        wait_quiet();

        // drive the pool to capacity and hit full a few times
        while (n_full < 8 && fill_guard < 3000)
        begin
            churn(92, 5, 1);
            fill_guard++;
        end

        repeat (150) churn(20, 65, 5);
        repeat (100) churn(45, 35, 5);

        wait_quiet();
        repeat (4) @(negedge clk);

        if (owed_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

        $display("covered %0d commands: %0d grants, %0d pool full, %0d compacts, %0d unknown ops",
                 n_taken, n_granted, n_full, n_compact, n_unknown);
        $display("error paths: %0d not issued, %0d none live; %0d pool collapses",
                 n_not_issued, n_none_live, n_collapse);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/sha_pkg.sv
design/slot_handle_allocator.sv
test/slot_handle_allocator_test.sv
